### hdl/convex_polygon_sat_collision_defines.svh
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision_defines
// assertion macros shared by the collision checker
// ----------------------------------------------------------------------------
`ifndef CONVEX_POLYGON_SAT_COLLISION_DEFINES_SVH
`define CONVEX_POLYGON_SAT_COLLISION_DEFINES_SVH

// same-cycle implication on clock, disabled in reset
`define CPSC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on clock, disabled in reset
`define CPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/cpsc_pkg.sv
// ----------------------------------------------------------------------------
// cpsc_pkg
// shared types and constants of the polygon collision block
// ----------------------------------------------------------------------------
package cpsc_pkg;

   localparam int MAX_VERTS_DEF  = 16;
   localparam int COORD_BITS_DEF = 16;
   localparam int RSP_DATA_W     = 8;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_OVF   = 2'd2
   } status_type;

   typedef struct packed {
      logic lat_vi;
      logic lat_n;
      logic edge_b;
      logic proj_vld;
      logic proj_b;
      logic proj_first;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic overlap;
   } stat_type;

endpackage

### hdl/convex_polygon_sat_collision.sv
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision
// separating axis collision test of two convex polygons, one vertex per beat
// ----------------------------------------------------------------------------
// req beats carry one vertex: tuser selects polygon a (0) or b (1), tlast
// marks the final vertex of that polygon. a vertices come first, then b.
// the final b vertex starts the test; every other beat gives no rsp beat.
// up to MAX_VERTS vertices per polygon are kept; more are dropped and the
// result reports overflow. an empty polygon a reports empty, collide 0.
// rsp carries one beat per test: collide and status.
// a test with na and nb stored vertices walks the na+nb axes: for each,
// states ST_EDGE0 to ST_EDGE2 form the edge normal, ST_PROJ makes one read
// per vertex through the single read port of each vertex ram, and ST_DRAIN
// waits for the multiply-add pipeline to drain; the first separating axis
// ends the test early.
// req_tready is low while a test runs. a held rsp beat does not block
// vertex beats; a finished test waits until the rsp register is free.
// reset empties both polygons and drops any pending rsp beat.
// ----------------------------------------------------------------------------
module convex_polygon_sat_collision #(
   parameter int MAX_VERTS  = cpsc_pkg::MAX_VERTS_DEF,
   parameter int COORD_BITS = cpsc_pkg::COORD_BITS_DEF,
   localparam int REQ_W     = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,  // vert_x, vert_y, zero pad
   input  logic                          req_tuser,  // poly_sel
   input  logic                          req_tlast,  // last_vertex
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cpsc_pkg::RSP_DATA_W-1:0] rsp_tdata // collide, status, zero pad
);
   import cpsc_pkg::*;

   localparam int AW = $clog2(MAX_VERTS);
   localparam int VW = 2 * COORD_BITS;

   logic          wr_a_en, wr_b_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [VW-1:0] rd_a, rd_b;
   logic [VW-1:0] vert_word;
   cmd_type       cmd;
   stat_type      stat;
   logic          rsp_collide;
   status_type    rsp_status;

   assign vert_word = req_tdata[VW-1:0];

   cpsc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (vert_word),
      .rd_addr (rd_addr),
      .rd_data (rd_a)
   );

   cpsc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (vert_word),
      .rd_addr (rd_addr),
      .rd_data (rd_b)
   );

   cpsc_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_collide (rsp_collide),
      .rsp_status  (rsp_status),
      .wr_a_en     (wr_a_en),
      .wr_b_en     (wr_b_en),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .cmd         (cmd),
      .stat        (stat)
   );

   cpsc_dp #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd_a  (rd_a),
      .rd_b  (rd_b),
      .stat  (stat)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 3){1'b0}}, rsp_status, rsp_collide};

endmodule

### hdl/cpsc_ram.sv
// ----------------------------------------------------------------------------
// cpsc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module cpsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/cpsc_ctrl.sv
// ----------------------------------------------------------------------------
// cpsc_ctrl
// vertex bookkeeping, axis and projection sequencer, result register
// ----------------------------------------------------------------------------
module cpsc_ctrl #(
   parameter int MAX_VERTS = cpsc_pkg::MAX_VERTS_DEF,
   localparam int AW = $clog2(MAX_VERTS),
   localparam int CW = $clog2(MAX_VERTS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_collide,
   output cpsc_pkg::status_type rsp_status,
   output logic                 wr_a_en,
   output logic                 wr_b_en,
   output logic [AW-1:0]        wr_addr,
   output logic [AW-1:0]        rd_addr,
   output cpsc_pkg::cmd_type    cmd,
   input  cpsc_pkg::stat_type   stat
);
   import cpsc_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EDGE0 = 7'b0000010,
      ST_EDGE1 = 7'b0000100,
      ST_EDGE2 = 7'b0001000,
      ST_PROJ  = 7'b0010000,
      ST_DRAIN = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTS);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_a_ff, cnt_a_in;
   logic [CW-1:0] cnt_b_ff, cnt_b_in;
   logic          a_done_ff, a_done_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_vld_ff, rsp_vld_in;
   logic          axis_b_ff, axis_b_in;
   logic [AW-1:0] axis_idx_ff, axis_idx_in;
   logic          proj_b_ff, proj_b_in;
   logic [AW-1:0] proj_idx_ff, proj_idx_in;
   logic          res_collide_ff, res_collide_in;
   status_type    res_status_ff, res_status_in;
   logic          rsp_collide_ff, rsp_collide_in;
   status_type    rsp_status_ff, rsp_status_in;

   logic          accept;
   logic [CW-1:0] base_a;
   logic [CW-1:0] axis_cnt;
   logic [CW-1:0] proj_cnt;
   logic          axis_last;
   logic          proj_last;
   logic [AW-1:0] j_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign base_a     = a_done_ff ? '0 : cnt_a_ff;
   assign axis_cnt   = axis_b_ff ? cnt_b_ff : cnt_a_ff;
   assign proj_cnt   = proj_b_ff ? cnt_b_ff : cnt_a_ff;
   assign axis_last  = ((CW'(axis_idx_ff) + CW'(1)) == axis_cnt);
   assign proj_last  = ((CW'(proj_idx_ff) + CW'(1)) == proj_cnt);
   assign j_idx      = axis_last ? '0 : axis_idx_ff + AW'(1);

   assign wr_a_en = accept && !req_tuser && (base_a < MAX_CNT);
   assign wr_b_en = accept && req_tuser && (cnt_b_ff < MAX_CNT);
   assign wr_addr = req_tuser ? cnt_b_ff[AW-1:0] : base_a[AW-1:0];

   always_comb begin
      unique case (state_ff)
         ST_EDGE0: rd_addr = axis_idx_ff;
         ST_EDGE1: rd_addr = j_idx;
         default:  rd_addr = proj_idx_ff;
      endcase
   end

   always_comb begin
      cmd.lat_vi     = (state_ff == ST_EDGE1);
      cmd.lat_n      = (state_ff == ST_EDGE2);
      cmd.edge_b     = axis_b_ff;
      cmd.proj_vld   = (state_ff == ST_PROJ);
      cmd.proj_b     = proj_b_ff;
      cmd.proj_first = (proj_idx_ff == '0);
   end

   always_comb begin
      state_in       = state_ff;
      cnt_a_in       = cnt_a_ff;
      cnt_b_in       = cnt_b_ff;
      a_done_in      = a_done_ff;
      ovf_in         = ovf_ff;
      rsp_vld_in     = rsp_vld_ff;
      axis_b_in      = axis_b_ff;
      axis_idx_in    = axis_idx_ff;
      proj_b_in      = proj_b_ff;
      proj_idx_in    = proj_idx_ff;
      res_collide_in = res_collide_ff;
      res_status_in  = res_status_ff;
      rsp_collide_in = rsp_collide_ff;
      rsp_status_in  = rsp_status_ff;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_tuser) begin
                  if (base_a < MAX_CNT) begin
                     cnt_a_in = base_a + CW'(1);
                  end else begin
                     cnt_a_in = base_a;
                     ovf_in   = 1'b1;
                  end
                  a_done_in = req_tlast;
               end else begin
                  if (cnt_b_ff < MAX_CNT) begin
                     cnt_b_in = cnt_b_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_tlast) begin
                     if (cnt_a_ff == '0) begin
                        res_collide_in = 1'b0;
                        res_status_in  = STAT_EMPTY;
                        state_in       = ST_DONE;
                     end else begin
                        axis_b_in   = 1'b0;
                        axis_idx_in = '0;
                        state_in    = ST_EDGE0;
                     end
                  end
               end
            end
         end
         ST_EDGE0: state_in = ST_EDGE1;
         ST_EDGE1: state_in = ST_EDGE2;
         ST_EDGE2: begin
            proj_b_in   = 1'b0;
            proj_idx_in = '0;
            state_in    = ST_PROJ;
         end
         ST_PROJ: begin
            if (proj_last) begin
               proj_idx_in = '0;
               if (!proj_b_ff) begin
                  proj_b_in = 1'b1;
               end else begin
                  state_in = ST_DRAIN;
               end
            end else begin
               proj_idx_in = proj_idx_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!stat.busy) begin
               priority if (!stat.overlap) begin
                  res_collide_in = 1'b0;
                  res_status_in  = ovf_ff ? STAT_OVF : STAT_OK;
                  state_in       = ST_DONE;
               end else if (axis_last && axis_b_ff) begin
                  res_collide_in = 1'b1;
                  res_status_in  = ovf_ff ? STAT_OVF : STAT_OK;
                  state_in       = ST_DONE;
               end else if (axis_last) begin
                  axis_b_in   = 1'b1;
                  axis_idx_in = '0;
                  state_in    = ST_EDGE0;
               end else begin
                  axis_idx_in = axis_idx_ff + AW'(1);
                  state_in    = ST_EDGE0;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in     = 1'b1;
               rsp_collide_in = res_collide_ff;
               rsp_status_in  = res_status_ff;
               cnt_a_in       = '0;
               cnt_b_in       = '0;
               a_done_in      = 1'b0;
               ovf_in         = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_a_ff   <= '0;
         cnt_b_ff   <= '0;
         a_done_ff  <= 1'b0;
         ovf_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_a_ff   <= cnt_a_in;
         cnt_b_ff   <= cnt_b_in;
         a_done_ff  <= a_done_in;
         ovf_ff     <= ovf_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_b_ff      <= axis_b_in;
      axis_idx_ff    <= axis_idx_in;
      proj_b_ff      <= proj_b_in;
      proj_idx_ff    <= proj_idx_in;
      res_collide_ff <= res_collide_in;
      res_status_ff  <= res_status_in;
      rsp_collide_ff <= rsp_collide_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_tvalid  = rsp_vld_ff;
   assign rsp_collide = rsp_collide_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

### hdl/cpsc_dp.sv
// ----------------------------------------------------------------------------
// cpsc_dp
// edge normal, pipelined dot product and projection interval datapath
// ----------------------------------------------------------------------------
module cpsc_dp #(
   parameter int COORD_BITS = cpsc_pkg::COORD_BITS_DEF,
   localparam int VW = 2 * COORD_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  cpsc_pkg::cmd_type   cmd,
   input  logic [VW-1:0]       rd_a,
   input  logic [VW-1:0]       rd_b,
   output cpsc_pkg::stat_type  stat
);
   import cpsc_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int PW = 2 * COORD_BITS + 1;
   localparam int DW = 2 * COORD_BITS + 2;

   logic [VW-1:0]        edge_word;
   logic [VW-1:0]        vi_ff, vi_in;
   logic signed [CB:0]   ex, ey;
   logic signed [CB:0]   nx_ff, nx_in;
   logic signed [CB:0]   ny_ff, ny_in;

   logic                 s1_vld_ff, s1_b_ff, s1_first_ff;
   logic                 s2_vld_ff, s2_b_ff, s2_first_ff;
   logic                 s3_vld_ff, s3_b_ff, s3_first_ff;

   logic [VW-1:0]        proj_word;
   logic signed [CB-1:0] sx, sy;
   logic signed [PW-1:0] px_ff, px_in;
   logic signed [PW-1:0] py_ff, py_in;
   logic signed [DW-1:0] dot_ff, dot_in;

   logic signed [DW-1:0] alo_ff, alo_in;
   logic signed [DW-1:0] ahi_ff, ahi_in;
   logic signed [DW-1:0] blo_ff, blo_in;
   logic signed [DW-1:0] bhi_ff, bhi_in;

   // edge vertex i, then vertex j, from the selected polygon
   assign edge_word = cmd.edge_b ? rd_b : rd_a;
   assign ex = $signed({vi_ff[CB-1], vi_ff[CB-1:0]})
             - $signed({edge_word[CB-1], edge_word[CB-1:0]});
   assign ey = $signed({vi_ff[VW-1], vi_ff[VW-1:CB]})
             - $signed({edge_word[VW-1], edge_word[VW-1:CB]});

   always_comb begin
      vi_in = cmd.lat_vi ? edge_word : vi_ff;
      nx_in = cmd.lat_n ? -ey : nx_ff;
      ny_in = cmd.lat_n ? ex : ny_ff;
   end

   assign proj_word = s1_b_ff ? rd_b : rd_a;
   assign sx        = $signed(proj_word[CB-1:0]);
   assign sy        = $signed(proj_word[VW-1:CB]);
   assign px_in     = nx_ff * sx;
   assign py_in     = ny_ff * sy;
   assign dot_in    = DW'(px_ff) + DW'(py_ff);

   always_comb begin
      alo_in = alo_ff;
      ahi_in = ahi_ff;
      blo_in = blo_ff;
      bhi_in = bhi_ff;
      if (s3_vld_ff) begin
         if (s3_b_ff) begin
            if (s3_first_ff || (dot_ff < blo_ff)) blo_in = dot_ff;
            if (s3_first_ff || (dot_ff > bhi_ff)) bhi_in = dot_ff;
         end else begin
            if (s3_first_ff || (dot_ff < alo_ff)) alo_in = dot_ff;
            if (s3_first_ff || (dot_ff > ahi_ff)) ahi_in = dot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.proj_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      vi_ff       <= vi_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      s1_b_ff     <= cmd.proj_b;
      s1_first_ff <= cmd.proj_first;
      s2_b_ff     <= s1_b_ff;
      s2_first_ff <= s1_first_ff;
      s3_b_ff     <= s2_b_ff;
      s3_first_ff <= s2_first_ff;
      px_ff       <= px_in;
      py_ff       <= py_in;
      dot_ff      <= dot_in;
      alo_ff      <= alo_in;
      ahi_ff      <= ahi_in;
      blo_ff      <= blo_in;
      bhi_ff      <= bhi_in;
   end

   // touching ends count as overlap
   always_comb begin
      stat.busy    = s1_vld_ff || s2_vld_ff || s3_vld_ff;
      stat.overlap = (bhi_ff >= alo_ff) && (blo_ff <= ahi_ff);
   end

endmodule

### hdl/cpsc_checker.sv
// ----------------------------------------------------------------------------
// cpsc_checker
// port level checks of the polygon collision block, bound to the top level
// ----------------------------------------------------------------------------
`include "convex_polygon_sat_collision_defines.svh"

module cpsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          req_tuser,
   input logic                          req_tlast,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [cpsc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import cpsc_pkg::*;

   logic req_beat;
   logic test_start;

   assign req_beat   = req_tvalid && req_tready;
   assign test_start = req_beat && req_tuser && req_tlast;

   `CPSC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")
   `CPSC_ASSERT_SAME(a_empty_no_hit, rsp_tvalid && (rsp_tdata[2:1] == STAT_EMPTY), !rsp_tdata[0], "collide set with empty polygon a")
   `CPSC_ASSERT_NEXT(a_busy_after_start, test_start, !req_tready, "req ready right after final b vertex")
   `CPSC_ASSERT_NEXT(a_ready_after_vertex, req_beat && !(req_tuser && req_tlast), req_tready, "req ready dropped after plain vertex")

endmodule

bind convex_polygon_sat_collision cpsc_checker u_cpsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### sim/convex_polygon_sat_collision_test.sv
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision_test
// self-checking bench for the polygon collision block
// ----------------------------------------------------------------------------
// streams vertex beats of polygon pairs into the block and predicts each
// collide/status beat with an exact integer separating axis test of its own.
// a short directed run covers touching polygons at full scale, an empty
// polygon a, a restarted polygon a, b vertices ahead of a, and single-point
// polygons. random pairs follow, mostly convex shapes of random size, with
// raw full-range vertices, overflowing polygons and stray beats mixed in.
// the sender idles in bursts, the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module convex_polygon_sat_collision_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cpsc_pkg::*;

   localparam int MAXV           = MAX_VERTS_DEF;
   localparam int CW             = COORD_BITS_DEF;
   localparam int REQ_W          = ((2 * CW + 7) / 8) * 8;
   localparam bit POLY_A         = 1'b0;
   localparam bit POLY_B         = 1'b1;
   localparam int ITEM_TARGET    = 600;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 1400;
   localparam int MAX_REPORTS    = 10;

   class collision_scoreboard;
      typedef struct {
         logic       collide;
         status_type status;
      } verdict_type;

      logic signed [CW-1:0] vx[2][MAXV];
      logic signed [CW-1:0] vy[2][MAXV];
      int                   count[2];
      bit                   a_done;
      bit                   dropped;
      verdict_type          verdict_q[$];
      int unsigned          faults;

      function new();
         count   = '{0, 0};
         a_done  = 1'b0;
         dropped = 1'b0;
         faults  = 0;
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction

      function void store(int side, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
         if (count[side] < MAXV) begin
            vx[side][count[side]] = x;
            vy[side][count[side]] = y;
            count[side]++;
         end else begin
            dropped = 1'b1;
         end
      endfunction

      function void project(longint nx, longint ny, int side,
                            output longint lo, output longint hi);
         longint d;
         lo = 0;
         hi = 0;
         for (int k = 0; k < count[side]; k++) begin
            d = nx * longint'(vx[side][k]) + ny * longint'(vy[side][k]);
            if (k == 0 || d < lo) lo = d;
            if (k == 0 || d > hi) hi = d;
         end
      endfunction

      // every edge normal of one polygon, both polygons projected on it
      function bit axes_overlap(int side);
         int     j;
         longint nx, ny, alo, ahi, blo, bhi;
         for (int i = 0; i < count[side]; i++) begin
            j  = (i + 1 < count[side]) ? i + 1 : 0;
            nx = longint'(vy[side][j]) - longint'(vy[side][i]);
            ny = longint'(vx[side][i]) - longint'(vx[side][j]);
            project(nx, ny, int'(POLY_A), alo, ahi);
            project(nx, ny, int'(POLY_B), blo, bhi);
            if (!(bhi >= alo && blo <= ahi)) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_vertex(bit sel, logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                bit last);
         verdict_type v;
         if (sel == POLY_A) begin
            if (a_done) begin
               count[POLY_A] = 0;
               a_done        = 1'b0;
            end
            store(int'(POLY_A), x, y);
            if (last) a_done = 1'b1;
            return;
         end
         store(int'(POLY_B), x, y);
         if (!last) return;
         if (count[POLY_A] == 0) begin
            v.collide = 1'b0;
            v.status  = STAT_EMPTY;
         end else begin
            v.collide = axes_overlap(int'(POLY_A)) && axes_overlap(int'(POLY_B));
            v.status  = dropped ? STAT_OVF : STAT_OK;
         end
         verdict_q.push_back(v);
         count   = '{0, 0};
         a_done  = 1'b0;
         dropped = 1'b0;
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         verdict_type v;
         if (verdict_q.size() == 0) begin
            faults++;
            if (faults <= MAX_REPORTS)
               $display("%0t: rsp beat with none pending: collide %0d status %0d pad %0h",
                        $realtime, data[0], data[2:1], data[RSP_DATA_W-1:3]);
            return;
         end
         v = verdict_q.pop_front();
         if (data[0] !== v.collide || data[2:1] !== v.status ||
             data[RSP_DATA_W-1:3] !== '0) begin
            faults++;
            if (faults <= MAX_REPORTS)
               $display("%0t: rsp mismatch: expected collide %0d status %0d, got collide %0d status %0d pad %0h",
                        $realtime, v.collide, v.status, data[0], data[2:1],
                        data[RSP_DATA_W-1:3]);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;  // vert_x, vert_y, zero pad
   logic                  req_tuser  = 1'b0; // poly_sel
   logic                  req_tlast  = 1'b0; // last_vertex
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // collide, status, zero pad

   collision_scoreboard sb = new();
   int                  items_sent  = 0;
   int                  burst_left  = 0;
   int                  idle_cycles = 0;
   logic [31:0]         ready_pattern = '1;
   int                  pattern_age   = 0;

   convex_polygon_sat_collision dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver stall pattern, reloaded when pattern_age reaches 96
   always @(posedge clock) begin
      if (pattern_age == 96) begin
         pattern_age <= 0;
         case ($urandom_range(0, 3))
            0: ready_pattern <= '1;
            1: ready_pattern <= $urandom;
            2: ready_pattern <= $urandom & $urandom & $urandom;
            default: ready_pattern <= $urandom | $urandom;
         endcase
      end else begin
         pattern_age   <= pattern_age + 1;
         ready_pattern <= {ready_pattern[30:0], ready_pattern[31]};
      end
      rsp_tready <= ready_pattern[0];
   end

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_vertex(req_tuser, req_tdata[CW-1:0], req_tdata[2*CW-1:CW], req_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("convex_polygon_sat_collision_test: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic int clamp_coord(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // cosine of k * 22.5 degrees, scaled by 64
   function automatic int ring_cos(int k);
      case (k % 16)
         0:  return 64;
         1:  return 59;
         2:  return 45;
         3:  return 24;
         4:  return 0;
         5:  return -24;
         6:  return -45;
         7:  return -59;
         8:  return -64;
         9:  return -59;
         10: return -45;
         11: return -24;
         12: return 0;
         13: return 24;
         14: return 45;
         default: return 59;
      endcase
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return $urandom_range(1, 2);
      if (r < 85) return $urandom_range(3, 8);
      if (r < 95) return $urandom_range(9, 16);
      return $urandom_range(17, 20);
   endfunction

   task automatic send_vertex(bit sel, logic [CW-1:0] x, logic [CW-1:0] y, bit last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= sel;
      req_tlast  <= last;
      req_tdata  <= {{(REQ_W - 2 * CW){1'b0}}, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // hold the sender until every pending rsp beat is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // convex shape on a 16-point ring, extra vertices beyond the ring are random
   task automatic send_shape(bit sel, int n, int cx, int cy, int r, bit raw, bit mark_last);
      int need, placed, start, k, px, py;
      need   = (n < 16) ? n : 16;
      placed = 0;
      start  = $urandom_range(0, 15);
      for (k = 0; k < 16 && placed < need; k++) begin
         if ($urandom_range(1, 16 - k) <= need - placed) begin
            px = clamp_coord(cx + ring_cos(k + start) * r / 64);
            py = clamp_coord(cy + ring_cos(k + start + 12) * r / 64);
            if (raw) begin
               px = $urandom;
               py = $urandom;
            end
            placed++;
            send_vertex(sel, px[CW-1:0], py[CW-1:0], mark_last && placed == n);
         end
      end
      while (placed < n) begin
         placed++;
         send_vertex(sel, CW'($urandom), CW'($urandom), mark_last && placed == n);
      end
   endtask

   initial begin
      int pick, n, r, ax, ay, bx, by;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // full-scale rectangles touching along x = 0
      send_vertex(POLY_A, 16'h8000, 16'h8000, 1'b0);
      send_vertex(POLY_A, 16'h0000, 16'h8000, 1'b0);
      send_vertex(POLY_A, 16'h0000, 16'h7fff, 1'b0);
      send_vertex(POLY_A, 16'h8000, 16'h7fff, 1'b1);
      send_vertex(POLY_B, 16'h0000, 16'h8000, 1'b0);
      send_vertex(POLY_B, 16'h7fff, 16'h8000, 1'b0);
      send_vertex(POLY_B, 16'h7fff, 16'h7fff, 1'b0);
      send_vertex(POLY_B, 16'h0000, 16'h7fff, 1'b1);
      // empty polygon a
      send_vertex(POLY_B, 16'd5, 16'd5, 1'b1);
      // finished a replaced by a new a, segments only
      send_vertex(POLY_A, 16'd0, 16'd0, 1'b0);
      send_vertex(POLY_A, 16'd10, 16'd0, 1'b1);
      send_vertex(POLY_A, 16'd500, 16'd500, 1'b0);
      send_vertex(POLY_A, 16'd510, 16'd500, 1'b1);
      send_vertex(POLY_B, 16'd0, 16'd0, 1'b0);
      send_vertex(POLY_B, 16'd10, 16'd0, 1'b1);
      // b vertex ahead of a
      send_vertex(POLY_B, 16'd0, 16'd0, 1'b0);
      send_vertex(POLY_A, 16'd1, 16'd1, 1'b0);
      send_vertex(POLY_A, 16'd3, 16'd1, 1'b0);
      send_vertex(POLY_A, 16'd2, 16'd3, 1'b1);
      send_vertex(POLY_B, 16'd2, 16'd2, 1'b0);
      send_vertex(POLY_B, 16'd4, 16'd4, 1'b1);
      // single points at opposite corners
      send_vertex(POLY_A, 16'h8000, 16'h7fff, 1'b1);
      send_vertex(POLY_B, 16'h7fff, 16'h8000, 1'b1);
      drain_results();

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 3))
               send_vertex(1'($urandom_range(0, 1)), CW'($urandom), CW'($urandom),
                           $urandom_range(0, 3) == 0);
         end else begin
            case ($urandom_range(0, 2))
               0: r = $urandom_range(1, 40);
               1: r = $urandom_range(40, 2000);
               default: r = $urandom_range(2000, 16000);
            endcase
            ax = $urandom_range(0, 20000) - 10000;
            ay = $urandom_range(0, 20000) - 10000;
            bx = ax + $urandom_range(0, 4 * r) - 2 * r;
            by = ay + $urandom_range(0, 4 * r) - 2 * r;
            n  = pick_size();
            send_shape(POLY_A, n, ax, ay, r, $urandom_range(0, 99) < 15,
                       $urandom_range(0, 9) != 0);
            n  = pick_size();
            send_shape(POLY_B, n, bx, by, r, $urandom_range(0, 99) < 15, 1'b1);
         end
         if ($urandom_range(0, 39) == 0) drain_results();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.faults == 0 && sb.pending() == 0)
         $display("convex_polygon_sat_collision_test: PASS");
      else
         $display("convex_polygon_sat_collision_test: FAIL");
      $finish;
   end

endmodule
